>>> src/jacn_pkg.sv
// shared constants, codes and types of the joystick calibrate and normalize block
package jacn_pkg;

    // field widths
    localparam int unsigned RAW_W   = 12;
    localparam int unsigned FRAC_W  = 15;
    localparam int unsigned NORM_W  = FRAC_W + 1;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned SUM_W   = 20;

    // converter full scale and the widths that follow from it
    localparam int unsigned ADC_FULL_SCALE = 4095;
    localparam int unsigned ADC_FS_W       = $clog2(ADC_FULL_SCALE + 1);
    localparam int unsigned DEN_W          = ((ADC_FS_W > RAW_W) ? ADC_FS_W : RAW_W) + 1;
    localparam int unsigned DIVISOR_W      = ((DEN_W - 1) > FRAC_W) ? (DEN_W - 1) : FRAC_W;

    // q1.15 plus one and reset values
    localparam int unsigned Q_ONE           = (1 << FRAC_W) - 1;
    localparam int unsigned DEADZONE_RESET  = 2621;
    localparam int unsigned CAL_COUNT_RESET = 50;
    localparam int unsigned CENTER_RESET    = 2048;

    // shared divider: widest dividend is the rescale product of two q1.15 values
    localparam int unsigned DIV_W              = 2 * FRAC_W;
    localparam int unsigned DIV_BITS_PER_CYCLE = 2;
    localparam int unsigned DIV_STEPS          = DIV_W / DIV_BITS_PER_CYCLE;
    localparam int unsigned DIV_CNT_W          = $clog2(DIV_STEPS + 1);

    // stream and configuration port widths
    localparam int unsigned S_TDATA_W   = ((2 * RAW_W + 1 + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W   = ((2 * NORM_W + 1 + 7) / 8) * 8;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = FRAC_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEADZONE  = 1'b0,
        CFG_CAL_COUNT = 1'b1
    } t_cfg_index;

    typedef enum logic {
        OP_CALIBRATE = 1'b0,
        OP_CONVERT   = 1'b1
    } t_op;

    typedef struct packed {
        logic [FRAC_W-1:0]  deadzone;
        logic [COUNT_W-1:0] cal_count;
    } t_cfg;

    typedef struct packed {
        t_op              op;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
        logic             switch_level;
    } t_item;

    typedef struct packed {
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic                     pressed;
        logic                     calibration_done;
    } t_result;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> src/jacn_div.sv
// shared unsigned shift-subtract divider, two quotient bits per cycle
module jacn_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jacn_pkg::t_div_req  i_req,
    output jacn_pkg::t_div_rsp  o_rsp
);

    logic                               r_busy;
    logic                               r_done;
    logic [jacn_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [jacn_pkg::DIVISOR_W-1:0]     r_rem;
    logic [jacn_pkg::DIV_W-1:0]         r_quo;
    logic [jacn_pkg::DIVISOR_W-1:0]     r_divisor;
    logic [jacn_pkg::DIVISOR_W-1:0]     n_rem;
    logic [jacn_pkg::DIV_W-1:0]         n_quo;

    // restoring steps for one cycle
    always_comb begin
        logic [jacn_pkg::DIVISOR_W:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int i = 0; i < jacn_pkg::DIV_BITS_PER_CYCLE; i++) begin
            trial = {n_rem, n_quo[jacn_pkg::DIV_W-1]};
            n_quo = {n_quo[jacn_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_divisor}) begin
                trial    = trial - {1'b0, r_divisor};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[jacn_pkg::DIVISOR_W-1:0];
        end
    end

    // iteration control and operand registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_cnt     <= (jacn_pkg::DIV_CNT_W)'(jacn_pkg::DIV_STEPS);
                r_rem     <= '0;
                r_quo     <= i_req.dividend;
                r_divisor <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - (jacn_pkg::DIV_CNT_W)'(1);
                if (r_cnt == (jacn_pkg::DIV_CNT_W)'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> src/jacn_core.sv
// sequencer: calibration sums and centers, per-axis normalize and deadzone rescale
module jacn_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jacn_pkg::t_cfg      i_cfg,
    input  logic                i_item_valid,
    output logic                o_item_ready,
    input  jacn_pkg::t_item     i_item,
    output logic                o_res_valid,
    input  logic                i_res_ack,
    output jacn_pkg::t_result   o_res,
    output jacn_pkg::t_div_req  o_div_req,
    input  jacn_pkg::t_div_rsp  i_div_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAL_START,
        S_CAL_DIV,
        S_NORM_START,
        S_NORM_DIV,
        S_DZ_START,
        S_DZ_DIV,
        S_RESULT
    } t_state;

    t_state                                 r_state;
    logic                                   r_axis;
    logic [jacn_pkg::RAW_W-1:0]             r_raw_x;
    logic [jacn_pkg::RAW_W-1:0]             r_raw_y;
    logic [jacn_pkg::RAW_W-1:0]             r_center_x;
    logic [jacn_pkg::RAW_W-1:0]             r_center_y;
    logic [jacn_pkg::SUM_W-1:0]             r_sum_x;
    logic [jacn_pkg::SUM_W-1:0]             r_sum_y;
    logic [jacn_pkg::COUNT_W-1:0]           r_sample_count;
    logic                                   r_q_neg;
    logic [jacn_pkg::FRAC_W-1:0]            r_q_mag;
    logic signed [jacn_pkg::NORM_W-1:0]     r_norm_x;
    logic signed [jacn_pkg::NORM_W-1:0]     r_norm_y;
    logic                                   r_pressed;
    logic                                   r_cal_done;

    logic [jacn_pkg::COUNT_W:0]             cal_n;
    logic [jacn_pkg::COUNT_W:0]             cal_need;
    logic [jacn_pkg::RAW_W-1:0]             sel_raw;
    logic [jacn_pkg::RAW_W-1:0]             sel_center;
    logic                                   raw_ge;
    logic [jacn_pkg::RAW_W-1:0]             num_mag;
    logic signed [jacn_pkg::DEN_W-1:0]      den_s;
    logic                                   den_neg;
    logic [jacn_pkg::DEN_W-1:0]             den_abs;
    logic [jacn_pkg::DIVISOR_W-1:0]         den_mag;
    logic                                   den_zero;
    logic [jacn_pkg::FRAC_W-1:0]            q_clamped;
    logic [jacn_pkg::FRAC_W-1:0]            span;
    logic [jacn_pkg::FRAC_W-1:0]            dz_diff;
    logic                                   dz_skip;
    logic [jacn_pkg::DIV_W-1:0]             dz_dividend;
    logic signed [jacn_pkg::NORM_W-1:0]     rescale_mag;
    logic signed [jacn_pkg::NORM_W-1:0]     rescale_val;

    // calibration count, a zero count acts as one
    assign cal_n    = {1'b0, r_sample_count} + (jacn_pkg::COUNT_W + 1)'(1);
    assign cal_need = (i_cfg.cal_count == '0) ? (jacn_pkg::COUNT_W + 1)'(1)
                                              : {1'b0, i_cfg.cal_count};

    // axis operands: offset magnitude and signed half-range denominator
    always_comb begin
        sel_raw    = r_axis ? r_raw_y : r_raw_x;
        sel_center = r_axis ? r_center_y : r_center_x;
        raw_ge     = (sel_raw >= sel_center);
        num_mag    = raw_ge ? (sel_raw - sel_center) : (sel_center - sel_raw);
        den_s      = raw_ge
                   ? $signed((jacn_pkg::DEN_W)'(jacn_pkg::ADC_FULL_SCALE)
                             - (jacn_pkg::DEN_W)'(sel_center))
                   : $signed((jacn_pkg::DEN_W)'(sel_center));
        den_neg    = den_s[jacn_pkg::DEN_W-1];
        den_abs    = den_neg ? $unsigned(-den_s) : $unsigned(den_s);
        den_mag    = (jacn_pkg::DIVISOR_W)'(den_abs);
        den_zero   = (den_s == '0);
    end

    // clamp of the first quotient to plus or minus one
    assign q_clamped = (i_div_rsp.quotient > (jacn_pkg::DIV_W)'(jacn_pkg::Q_ONE))
                     ? (jacn_pkg::FRAC_W)'(jacn_pkg::Q_ONE)
                     : i_div_rsp.quotient[jacn_pkg::FRAC_W-1:0];

    // deadzone test and rescale product (x * 32767 as shift minus x)
    always_comb begin
        span        = (jacn_pkg::FRAC_W)'(jacn_pkg::Q_ONE) - i_cfg.deadzone;
        dz_diff     = r_q_mag - i_cfg.deadzone;
        dz_skip     = (r_q_mag < i_cfg.deadzone) || (span == '0);
        dz_dividend = {dz_diff, {jacn_pkg::FRAC_W{1'b0}}} - (jacn_pkg::DIV_W)'(dz_diff);
        rescale_mag = $signed({1'b0, i_div_rsp.quotient[jacn_pkg::FRAC_W-1:0]});
        rescale_val = r_q_neg ? -rescale_mag : rescale_mag;
    end

    // divider requests
    always_comb begin
        o_div_req = '0;
        unique case (r_state)
            S_CAL_START: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = (jacn_pkg::DIV_W)'(r_axis ? r_sum_y : r_sum_x);
                o_div_req.divisor  = (jacn_pkg::DIVISOR_W)'(cal_n);
            end
            S_NORM_START: begin
                o_div_req.start    = !den_zero;
                o_div_req.dividend = (jacn_pkg::DIV_W)'({num_mag,
                                                         {jacn_pkg::FRAC_W{1'b0}}});
                o_div_req.divisor  = den_mag;
            end
            S_DZ_START: begin
                o_div_req.start    = !dz_skip;
                o_div_req.dividend = dz_dividend;
                o_div_req.divisor  = (jacn_pkg::DIVISOR_W)'(span);
            end
            default: begin
                o_div_req = '0;
            end
        endcase
    end

    // sequencer, block state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_axis         <= 1'b0;
            r_center_x     <= (jacn_pkg::RAW_W)'(jacn_pkg::CENTER_RESET);
            r_center_y     <= (jacn_pkg::RAW_W)'(jacn_pkg::CENTER_RESET);
            r_sum_x        <= '0;
            r_sum_y        <= '0;
            r_sample_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_raw_x    <= i_item.raw_x;
                        r_raw_y    <= i_item.raw_y;
                        r_pressed  <= ~i_item.switch_level;
                        r_cal_done <= 1'b0;
                        r_norm_x   <= '0;
                        r_norm_y   <= '0;
                        r_axis     <= 1'b0;
                        if (i_item.op == jacn_pkg::OP_CALIBRATE) begin
                            r_sum_x <= r_sum_x + (jacn_pkg::SUM_W)'(i_item.raw_x);
                            r_sum_y <= r_sum_y + (jacn_pkg::SUM_W)'(i_item.raw_y);
                            if (cal_n >= cal_need) begin
                                r_state <= S_CAL_START;
                            end else begin
                                r_sample_count <= cal_n[jacn_pkg::COUNT_W-1:0];
                                r_state        <= S_RESULT;
                            end
                        end else begin
                            r_state <= S_NORM_START;
                        end
                    end
                end
                S_CAL_START: begin
                    r_state <= S_CAL_DIV;
                end
                S_CAL_DIV: begin
                    if (i_div_rsp.done) begin
                        if (!r_axis) begin
                            r_center_x <= i_div_rsp.quotient[jacn_pkg::RAW_W-1:0];
                            r_axis     <= 1'b1;
                            r_state    <= S_CAL_START;
                        end else begin
                            r_center_y     <= i_div_rsp.quotient[jacn_pkg::RAW_W-1:0];
                            r_sum_x        <= '0;
                            r_sum_y        <= '0;
                            r_sample_count <= '0;
                            r_cal_done     <= 1'b1;
                            r_state        <= S_RESULT;
                        end
                    end
                end
                S_NORM_START: begin
                    r_q_neg <= (!raw_ge) ^ den_neg;
                    if (den_zero) begin
                        // zero denominator leaves this axis at zero
                        if (r_axis) begin
                            r_state <= S_RESULT;
                        end else begin
                            r_axis  <= 1'b1;
                            r_state <= S_NORM_START;
                        end
                    end else begin
                        r_state <= S_NORM_DIV;
                    end
                end
                S_NORM_DIV: begin
                    if (i_div_rsp.done) begin
                        r_q_mag <= q_clamped;
                        r_state <= S_DZ_START;
                    end
                end
                S_DZ_START: begin
                    if (dz_skip) begin
                        // inside the deadzone or no span left: axis stays zero
                        if (r_axis) begin
                            r_state <= S_RESULT;
                        end else begin
                            r_axis  <= 1'b1;
                            r_state <= S_NORM_START;
                        end
                    end else begin
                        r_state <= S_DZ_DIV;
                    end
                end
                S_DZ_DIV: begin
                    if (i_div_rsp.done) begin
                        if (r_axis) begin
                            r_norm_y <= rescale_val;
                            r_state  <= S_RESULT;
                        end else begin
                            r_norm_x <= rescale_val;
                            r_axis   <= 1'b1;
                            r_state  <= S_NORM_START;
                        end
                    end
                end
                S_RESULT: begin
                    if (i_res_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_item_ready           = (r_state == S_IDLE);
    assign o_res_valid            = (r_state == S_RESULT);
    assign o_res.norm_x           = r_norm_x;
    assign o_res.norm_y           = r_norm_y;
    assign o_res.pressed          = r_pressed;
    assign o_res.calibration_done = r_cal_done;

endmodule

>>> src/joystick_axis_calibrate_normalize_top.sv
// top level: stream ports, configuration registers, output register, shared divider
//
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: raw_x, raw_y, switch_level
//                                               tuser: operation
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: norm_x, norm_y, pressed
//                                               tuser: calibration_done
// cfg       in   i_cfg_valid / o_cfg_ready      index 0 deadzone, 1 calibration count
//
// one item at a time; a calibration sample that does not finish the run needs no division,
// one that finishes it two divisions, a convert sample up to four divisions; every
// division has a start step, the divider steps at two quotient bits per cycle and a done
// step. reset is synchronous, active low, and brings the centers back to mid scale. the
// output register lets a new sample in while a result waits; a stalled output holds the
// sequencer at its last step.
module joystick_axis_calibrate_normalize_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [11:0] raw_x, [23:12] raw_y, [24] switch_level, rest zero
    input  logic [jacn_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // [0] operation
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [15:0] norm_x, [31:16] norm_y, [32] pressed, rest zero
    output logic [jacn_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // [0] calibration_done
    output logic                                 m_axis_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [jacn_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [jacn_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [jacn_pkg::FRAC_W-1:0]    r_deadzone;
    logic [jacn_pkg::COUNT_W-1:0]   r_cal_count;
    logic                           r_m_valid;
    jacn_pkg::t_result              r_m_data;

    jacn_pkg::t_cfg                 cfg;
    jacn_pkg::t_item                item;
    jacn_pkg::t_result              res;
    jacn_pkg::t_div_req             div_req;
    jacn_pkg::t_div_rsp             div_rsp;
    logic                           item_ready;
    logic                           res_valid;
    logic                           res_ack;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone  <= (jacn_pkg::FRAC_W)'(jacn_pkg::DEADZONE_RESET);
            r_cal_count <= (jacn_pkg::COUNT_W)'(jacn_pkg::CAL_COUNT_RESET);
        end else if (i_cfg_valid) begin
            unique case (jacn_pkg::t_cfg_index'(i_cfg_index))
                jacn_pkg::CFG_DEADZONE: begin
                    r_deadzone <= i_cfg_data;
                end
                jacn_pkg::CFG_CAL_COUNT: begin
                    r_cal_count <= i_cfg_data[jacn_pkg::COUNT_W-1:0];
                end
                default: begin
                    r_deadzone <= r_deadzone;
                end
            endcase
        end
    end

    assign cfg.deadzone  = r_deadzone;
    assign cfg.cal_count = r_cal_count;

    // input unpacking
    assign item.op           = jacn_pkg::t_op'(s_axis_tuser);
    assign item.raw_x        = s_axis_tdata[jacn_pkg::RAW_W-1:0];
    assign item.raw_y        = s_axis_tdata[2*jacn_pkg::RAW_W-1:jacn_pkg::RAW_W];
    assign item.switch_level = s_axis_tdata[2*jacn_pkg::RAW_W];
    assign s_axis_tready     = item_ready;

    jacn_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (item_ready),
        .i_item       (item),
        .o_res_valid  (res_valid),
        .i_res_ack    (res_ack),
        .o_res        (res),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp)
    );

    jacn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // output register, loads when empty or being emptied by a transfer
    assign res_ack = res_valid && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ack) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ack) begin
            r_m_data <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = (jacn_pkg::M_TDATA_W)'({r_m_data.pressed, r_m_data.norm_y,
                                                   r_m_data.norm_x});
    assign m_axis_tuser  = r_m_data.calibration_done;

    // a result that closes calibration carries zero positions
    a_cal_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[2*jacn_pkg::NORM_W-1:0] == '0))
        else $error("calibration result with nonzero position");

    // positions stay within plus or minus one
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_m_data.norm_x != {1'b1, {jacn_pkg::FRAC_W{1'b0}}})
                          && (r_m_data.norm_y != {1'b1, {jacn_pkg::FRAC_W{1'b0}}}))
        else $error("normalized position out of range");

    // an accepted sample closes the input until its result is handed over
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened right after a transfer");

    // the divider is never restarted while the sequencer waits for a result
    a_no_div_at_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !div_req.start)
        else $error("division started while a result waits");

endmodule
